FILE: hw/rtl/bmpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpd_pkg: shared types and constants of the BMP 24-bit stream decoder
// Result word layout, result kinds, header field positions and limits.
// ----------------------------------------------------------------------------
package bmpd_pkg;

  // Default image size limits
  localparam int BMP_MAX_WIDTH  = 4096;
  localparam int BMP_MAX_HEIGHT = 4096;

  // Header layout (byte positions within the file)
  localparam logic [31:0] HDR_SIZE       = 32'd54;
  localparam logic [31:0] HDR_LAST       = 32'd53;
  localparam logic [31:0] POS_SIG_B      = 32'd0;
  localparam logic [31:0] POS_SIG_M      = 32'd1;
  localparam logic [31:0] POS_OFFSET     = 32'd10;
  localparam logic [31:0] POS_WIDTH      = 32'd18;
  localparam logic [31:0] POS_HEIGHT     = 32'd22;
  localparam logic [31:0] POS_DEPTH      = 32'd28;
  localparam logic [7:0]  ASCII_B        = 8'h42;
  localparam logic [7:0]  ASCII_M        = 8'h4D;
  localparam logic [15:0] DEPTH_24       = 16'd24;

  // Output queue depth (two slots of headroom per accepted byte)
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    KIND_PIXEL     = 3'd0,
    KIND_DONE      = 3'd1,
    KIND_NOT_BMP   = 3'd2,
    KIND_BAD_DEPTH = 3'd3,
    KIND_INVALID   = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] row;
    logic        final_res;
  } res_t;

  // Up to two result words produced by one input byte
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

FILE: hw/rtl/bmpd_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpd_out_queue: result word queue
// Small register queue that takes zero, one or two words per cycle and
// hands one word per cycle to the output stream while pop is asserted.
// ----------------------------------------------------------------------------
module bmpd_out_queue
  import bmpd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  head_valid,
  output res_t  head,
  input  logic  pop
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  res_t          mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_pop;

  assign do_pop     = pop && (count != '0);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign room       = (count <= CW'(QUEUE_DEPTH - 2));

  // Store incoming words
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + PW'(1)] <= push.second;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.count);
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CW'(push.count) - CW'(do_pop);
    end
  end

endmodule

FILE: hw/rtl/bmp24_stream_decoder.sv
`timescale 1ns / 1ps
// Each result word is queued as the byte causing it is accepted. Throughput:
// one byte per cycle while the queue has room; a byte may cause up to two
// words, drained one per cycle while m_tready is high, via a four-word queue.
// Reset (rst, synchronous): returns to the header phase and empties the queue.
// End of file on the last byte of a file also restarts the header phase.
// ----------------------------------------------------------------------------
// bmp24_stream_decoder: 24-bit BMP byte stream to RGB pixel words
// Parses the 54-byte header, skips to the pixel data, emits one pixel word
// per B,G,R triple with top-down row and column, and closes each file with a
// done or error word.
// ----------------------------------------------------------------------------
module bmp24_stream_decoder
  import bmpd_pkg::*;
#(
  parameter int MAX_WIDTH  = BMP_MAX_WIDTH,
  parameter int MAX_HEIGHT = BMP_MAX_HEIGHT
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_file
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                 // [35:24] column, [47:36] row
  output logic [2:0]  m_tuser,   // [2:0] kind
  output logic        m_tlast    // final_res
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int RBW = $clog2(3 * MAX_WIDTH + 4);
  localparam int CXW = (WW > 12) ? WW : 12;
  localparam int RXW = (HW > 12) ? HW : 12;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXEL,
    PH_DRAIN
  } phase_t;

  // Parser state
  phase_t         phase,        phase_next;
  logic [31:0]    byte_pos,     byte_pos_next;
  logic [31:0]    pix_offset,   pix_offset_next;
  logic [31:0]    img_width,    img_width_next;
  logic [31:0]    img_height,   img_height_next;
  logic [15:0]    depth_bits,   depth_bits_next;
  logic           sig_ok,       sig_ok_next;
  logic [7:0]     held_blue,    held_blue_next;
  logic [7:0]     held_green,   held_green_next;
  logic [RBW-1:0] byte_in_row,  byte_in_row_next;
  logic [WW-1:0]  col_cnt,      col_cnt_next;
  logic [1:0]     sel_cnt,      sel_cnt_next;
  logic [HW-1:0]  file_row,     file_row_next;

  logic           acc;
  logic           eof;
  logic [7:0]     din;
  logic           fin;
  logic           complete;
  logic           go_pixels;
  logic           hdr_bad;
  kind_t          hdr_kind;
  logic [RBW-1:0] w3;
  logic [RBW-1:0] row_bytes;
  logic [RBW-1:0] bir_inc;
  logic [HW-1:0]  row_inc;
  logic [CXW-1:0] col_ext;
  logic [RXW-1:0] row_ext;
  push_t          push;
  res_t           head;
  logic           room;
  logic           head_valid;

  function automatic res_t close_word(kind_t k);
    res_t r;
    r           = '0;
    r.kind      = k;
    r.final_res = 1'b1;
    return r;
  endfunction

  assign acc = s_tvalid && s_tready;
  assign eof = s_tlast;
  assign din = s_tdata;

  // Row geometry: 3 bytes per pixel, rounded up to a multiple of 4
  assign w3        = (RBW'(img_width[WW-1:0]) << 1) + RBW'(img_width[WW-1:0]);
  assign row_bytes = (w3 + RBW'(3)) & ~RBW'(3);
  assign bir_inc   = byte_in_row + RBW'(1);
  assign row_inc   = file_row + HW'(1);
  assign col_ext   = CXW'(col_cnt);
  assign row_ext   = RXW'(img_height[HW-1:0]) - RXW'(file_row) - RXW'(1);

  // Header checks, in priority order
  always_comb begin
    hdr_bad  = 1'b1;
    hdr_kind = KIND_INVALID;
    if (!sig_ok) begin
      hdr_kind = KIND_NOT_BMP;
    end else if (depth_bits != DEPTH_24) begin
      hdr_kind = KIND_BAD_DEPTH;
    end else if (img_width[31] || img_height[31] ||
                 (img_width > 32'(MAX_WIDTH)) || (img_height > 32'(MAX_HEIGHT)) ||
                 (pix_offset < HDR_SIZE)) begin
      hdr_kind = KIND_INVALID;
    end else begin
      hdr_bad = 1'b0;
    end
  end

  // Per-byte step: next state and result words
  always_comb begin
    phase_next       = phase;
    byte_pos_next    = byte_pos;
    pix_offset_next  = pix_offset;
    img_width_next   = img_width;
    img_height_next  = img_height;
    depth_bits_next  = depth_bits;
    sig_ok_next      = sig_ok;
    held_blue_next   = held_blue;
    held_green_next  = held_green;
    byte_in_row_next = byte_in_row;
    col_cnt_next     = col_cnt;
    sel_cnt_next     = sel_cnt;
    file_row_next    = file_row;
    push             = '0;
    fin              = 1'b0;
    complete         = 1'b0;
    go_pixels        = 1'b0;

    case (phase)
      PH_HEADER: begin
        if ((byte_pos == POS_SIG_B) && (din != ASCII_B)) begin
          sig_ok_next = 1'b0;
        end
        if ((byte_pos == POS_SIG_M) && (din != ASCII_M)) begin
          sig_ok_next = 1'b0;
        end
        // Capture little-endian header fields
        case (byte_pos)
          POS_OFFSET:             pix_offset_next[7:0]   = din;
          POS_OFFSET + 32'd1:     pix_offset_next[15:8]  = din;
          POS_OFFSET + 32'd2:     pix_offset_next[23:16] = din;
          POS_OFFSET + 32'd3:     pix_offset_next[31:24] = din;
          POS_WIDTH:              img_width_next[7:0]    = din;
          POS_WIDTH + 32'd1:      img_width_next[15:8]   = din;
          POS_WIDTH + 32'd2:      img_width_next[23:16]  = din;
          POS_WIDTH + 32'd3:      img_width_next[31:24]  = din;
          POS_HEIGHT:             img_height_next[7:0]   = din;
          POS_HEIGHT + 32'd1:     img_height_next[15:8]  = din;
          POS_HEIGHT + 32'd2:     img_height_next[23:16] = din;
          POS_HEIGHT + 32'd3:     img_height_next[31:24] = din;
          POS_DEPTH:              depth_bits_next[7:0]   = din;
          POS_DEPTH + 32'd1:      depth_bits_next[15:8]  = din;
          default: ;
        endcase
        byte_pos_next = byte_pos + 32'd1;
        if (byte_pos < HDR_LAST) begin
          if (eof) begin
            push.count = 2'd1;
            push.first = close_word(KIND_NOT_BMP);
            fin        = 1'b1;
          end
        end else if (hdr_bad) begin
          push.count = 2'd1;
          push.first = close_word(hdr_kind);
          fin        = 1'b1;
        end else if (pix_offset == HDR_SIZE) begin
          go_pixels = 1'b1;
        end else begin
          phase_next = PH_SKIP;
        end
      end
      PH_SKIP: begin
        byte_pos_next = byte_pos + 32'd1;
        if ((byte_pos + 32'd1) == pix_offset) begin
          go_pixels = 1'b1;
        end
      end
      PH_PIXEL: begin
        // Collect B, G, then emit on R; padding bytes fall through
        if (col_cnt < img_width[WW-1:0]) begin
          case (sel_cnt)
            2'd0: held_blue_next = din;
            2'd1: held_green_next = din;
            default: begin
              push.count        = 2'd1;
              push.first.kind   = KIND_PIXEL;
              push.first.red    = din;
              push.first.green  = held_green;
              push.first.blue   = held_blue;
              push.first.column = col_ext[11:0];
              push.first.row    = row_ext[11:0];
            end
          endcase
          if (sel_cnt == 2'd2) begin
            sel_cnt_next = 2'd0;
            col_cnt_next = col_cnt + WW'(1);
          end else begin
            sel_cnt_next = sel_cnt + 2'd1;
          end
        end
        byte_in_row_next = bir_inc;
        if (bir_inc == row_bytes) begin
          byte_in_row_next = '0;
          col_cnt_next     = '0;
          sel_cnt_next     = 2'd0;
          file_row_next    = row_inc;
          if (row_inc == img_height[HW-1:0]) begin
            complete = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // Enter pixel data; an empty image finishes at once
    if (go_pixels) begin
      phase_next       = PH_PIXEL;
      byte_in_row_next = '0;
      col_cnt_next     = '0;
      sel_cnt_next     = 2'd0;
      file_row_next    = '0;
      complete         = (img_height == 32'd0) || (img_width == 32'd0);
    end

    // Closing word: done, or a file cut short
    if ((phase != PH_DRAIN) && !fin) begin
      if (complete || (eof && (phase_next != PH_HEADER))) begin
        fin = 1'b1;
        if (push.count == 2'd0) begin
          push.count = 2'd1;
          push.first = close_word(complete ? KIND_DONE : KIND_INVALID);
        end else begin
          push.count  = 2'd2;
          push.second = close_word(complete ? KIND_DONE : KIND_INVALID);
        end
      end
    end

    // Drop the rest of the file, restart on end of file
    if (fin) begin
      phase_next = PH_DRAIN;
    end
    if (((phase == PH_DRAIN) || fin) && eof) begin
      phase_next    = PH_HEADER;
      byte_pos_next = '0;
      sig_ok_next   = 1'b1;
    end

    if (!acc) begin
      push.count = 2'd0;
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      byte_pos <= '0;
      sig_ok   <= 1'b1;
    end else if (acc) begin
      phase    <= phase_next;
      byte_pos <= byte_pos_next;
      sig_ok   <= sig_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pix_offset  <= pix_offset_next;
      img_width   <= img_width_next;
      img_height  <= img_height_next;
      depth_bits  <= depth_bits_next;
      held_blue   <= held_blue_next;
      held_green  <= held_green_next;
      byte_in_row <= byte_in_row_next;
      col_cnt     <= col_cnt_next;
      sel_cnt     <= sel_cnt_next;
      file_row    <= file_row_next;
    end
  end

  // Result queue toward the master side
  bmpd_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .head_valid (head_valid),
    .head       (head),
    .pop        (m_tready)
  );

  assign s_tready = room;
  assign m_tvalid = head_valid;
  assign m_tdata  = {head.row, head.column, head.blue, head.green, head.red};
  assign m_tuser  = head.kind;
  assign m_tlast  = head.final_res;

  // Checks
  a_last_is_close: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser != KIND_PIXEL)))
    else $error("final flag and kind disagree");

  a_close_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != KIND_PIXEL)) |-> (m_tdata == 48'd0))
    else $error("closing word carries pixel data");

  a_eof_restart: assert property (@(posedge clk) disable iff (rst)
    (acc && fin && eof) |=> ((phase == PH_HEADER) && (byte_pos == 32'd0)))
    else $error("no restart after closing word on end of file");

  a_sel_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PIXEL) |-> (sel_cnt != 2'd3))
    else $error("color byte select out of range");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the BMP 24-bit stream decoder
// Feeds whole BMP files a byte at a time (well-formed images of many sizes,
// header errors, truncated files, noise) and mirrors the decoder in a
// bit-accurate parser. Every result word is checked in order, under several
// sender and receiver pacing phases.
// ----------------------------------------------------------------------------
module tb;
  import bmpd_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXEL,
    PH_DRAIN
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } file_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  // Stimulus and expected-result stores
  file_byte_t  bytes_to_send[$];
  res_t        words_due[$];
  int          bytes_queued = 0;
  int          bytes_accepted = 0;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  logic        byte_taken = 1'b0;

  // Parser state mirrored from the decoder
  parse_phase_t ph;
  logic [31:0]  hdr_pos;
  logic [31:0]  pix_offset;
  logic [31:0]  img_width;
  logic [31:0]  img_height;
  logic [15:0]  img_depth;
  logic         sig_ok;
  logic [7:0]   keep_blue;
  logic [7:0]   keep_green;
  logic [31:0]  row_byte;
  logic [31:0]  file_row;

  bmp24_stream_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial forever #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  task automatic clear_parser();
    ph         = PH_HEADER;
    hdr_pos    = '0;
    pix_offset = '0;
    img_width  = '0;
    img_height = '0;
    img_depth  = '0;
    sig_ok     = 1'b1;
    keep_blue  = '0;
    keep_green = '0;
    row_byte   = '0;
    file_row   = '0;
  endtask

  function automatic logic [31:0] padded_row();
    return ((img_width * 32'd3) + 32'd3) & ~32'd3;
  endfunction

  function automatic res_t make_word(kind_t k, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic [11:0] col, logic [11:0] rw, logic fin);
    res_t w;
    w.kind      = k;
    w.red       = r;
    w.green     = g;
    w.blue      = b;
    w.column    = col;
    w.row       = rw;
    w.final_res = fin;
    return w;
  endfunction

  function automatic string word_text(res_t w);
    return $sformatf("kind=%0d rgb=%02h_%02h_%02h col=%0d row=%0d last=%b",
                     w.kind, w.red, w.green, w.blue, w.column, w.row, w.final_res);
  endfunction

  // Enter the pixel phase; flag an image with no pixel bytes at all
  task automatic start_pixels(output bit empty);
    ph       = PH_PIXEL;
    row_byte = '0;
    file_row = '0;
    empty    = (img_height == 32'd0) || (padded_row() == 32'd0);
  endtask

  // Advance the parser by one file byte and queue the words it causes
  task automatic decode_byte(input logic [7:0] b, input logic eof);
    bit          fin;
    bit          complete;
    kind_t       k;
    logic [31:0] p;
    logic [31:0] rw;
    logic [31:0] col;
    fin      = 1'b0;
    complete = 1'b0;
    if (ph == PH_DRAIN) begin
      if (eof) clear_parser();
    end else begin
      if (ph == PH_HEADER) begin
        p = hdr_pos;
        if (p == POS_SIG_B && b != ASCII_B) sig_ok = 1'b0;
        if (p == POS_SIG_M && b != ASCII_M) sig_ok = 1'b0;
        if (p >= POS_OFFSET && p < POS_OFFSET + 32'd4) pix_offset[8*(p-POS_OFFSET) +: 8] = b;
        if (p >= POS_WIDTH && p < POS_WIDTH + 32'd4) img_width[8*(p-POS_WIDTH) +: 8] = b;
        if (p >= POS_HEIGHT && p < POS_HEIGHT + 32'd4) img_height[8*(p-POS_HEIGHT) +: 8] = b;
        if (p >= POS_DEPTH && p < POS_DEPTH + 32'd2) img_depth[8*(p-POS_DEPTH) +: 8] = b;
        hdr_pos = p + 32'd1;
        if (p < HDR_LAST) begin
          if (eof) begin
            words_due.push_back(make_word(KIND_NOT_BMP, '0, '0, '0, '0, '0, 1'b1));
            fin = 1'b1;
          end
        end else begin
          // Header complete: check in priority order
          k = KIND_PIXEL;
          if (!sig_ok) begin
            k = KIND_NOT_BMP;
          end else if (img_depth != DEPTH_24) begin
            k = KIND_BAD_DEPTH;
          end else if (img_width[31] || img_height[31] ||
                       img_width > 32'(BMP_MAX_WIDTH) || img_height > 32'(BMP_MAX_HEIGHT) ||
                       pix_offset < HDR_SIZE) begin
            k = KIND_INVALID;
          end
          if (k != KIND_PIXEL) begin
            words_due.push_back(make_word(k, '0, '0, '0, '0, '0, 1'b1));
            fin = 1'b1;
          end else if (pix_offset == HDR_SIZE) begin
            start_pixels(complete);
          end else begin
            ph = PH_SKIP;
          end
        end
      end else if (ph == PH_SKIP) begin
        hdr_pos = hdr_pos + 32'd1;
        if (hdr_pos == pix_offset) start_pixels(complete);
      end else begin
        // Pixel bytes come as B, G, R; padding bytes are dropped
        if (row_byte < img_width * 32'd3) begin
          case (row_byte % 32'd3)
            32'd0: keep_blue = b;
            32'd1: keep_green = b;
            default: begin
              col = row_byte / 32'd3;
              rw  = img_height - 32'd1 - file_row;
              words_due.push_back(make_word(KIND_PIXEL, b, keep_green, keep_blue,
                                            col[11:0], rw[11:0], 1'b0));
            end
          endcase
        end
        row_byte = row_byte + 32'd1;
        if (row_byte >= padded_row()) begin
          row_byte = '0;
          file_row = file_row + 32'd1;
          if (file_row >= img_height) complete = 1'b1;
        end
      end

      if (!fin) begin
        if (complete) begin
          words_due.push_back(make_word(KIND_DONE, '0, '0, '0, '0, '0, 1'b1));
          fin = 1'b1;
        end else if (eof && ph != PH_HEADER) begin
          words_due.push_back(make_word(KIND_INVALID, '0, '0, '0, '0, '0, 1'b1));
          fin = 1'b1;
        end
      end

      if (fin) begin
        if (eof) clear_parser();
        else ph = PH_DRAIN;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // File builders
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] d, input logic l);
    bytes_to_send.push_back('{data: d, last: l});
    bytes_queued++;
  endtask

  // Build one file: header fields, optional corrupted header byte, filler up to
  // the offset, padded pixel rows; then truncate or append ignored trailing bytes
  task automatic queue_file(input logic [31:0] w, input logic [31:0] h, input logic [31:0] off,
                            input logic [15:0] bpp, input logic [7:0] sig0,
                            input logic [7:0] sig1, input int cut, input int tail,
                            input int flip);
    logic [7:0]  img[$];
    logic [31:0] row_len;
    int          i;
    int          n;
    row_len = ((w * 32'd3) + 32'd3) & ~32'd3;
    for (i = 0; i < HDR_SIZE; i++) img.push_back(8'($urandom_range(255)));
    img[POS_SIG_B] = sig0;
    img[POS_SIG_M] = sig1;
    for (i = 0; i < 4; i++) begin
      img[POS_OFFSET + i] = off[8*i +: 8];
      img[POS_WIDTH + i]  = w[8*i +: 8];
      img[POS_HEIGHT + i] = h[8*i +: 8];
    end
    img[POS_DEPTH]         = bpp[7:0];
    img[POS_DEPTH + 32'd1] = bpp[15:8];
    if (flip >= 0) img[flip] = img[flip] ^ 8'($urandom_range(1, 255));
    if (off >= HDR_SIZE && off <= 32'd300 && !w[31] && !h[31] &&
        w <= 32'(BMP_MAX_WIDTH) && h <= 32'(BMP_MAX_HEIGHT) && row_len * h <= 32'd20000) begin
      while (img.size() < off) img.push_back(8'($urandom_range(255)));
      repeat (row_len * h) img.push_back(8'($urandom_range(255)));
    end
    n = img.size();
    if (cut > 0 && cut < n) begin
      n = cut;
    end else begin
      repeat (tail) begin
        img.push_back(8'($urandom_range(255)));
        n++;
      end
    end
    for (i = 0; i < n; i++) push_byte(img[i], i == n - 1);
  endtask

  task automatic queue_random_file();
    int          pick;
    int          i;
    int          n;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] off;
    logic [31:0] len;
    logic [15:0] bpp;
    logic [7:0]  s0;
    logic [7:0]  s1;
    pick = $urandom_range(99);
    w    = ($urandom_range(9) == 0) ? 32'd0 : 32'($urandom_range(1, 12));
    h    = ($urandom_range(9) == 0) ? 32'd0 : 32'($urandom_range(1, 6));
    off  = $urandom_range(1) ? HDR_SIZE : 32'($urandom_range(55, 70));
    bpp  = DEPTH_24;
    s0   = ASCII_B;
    s1   = ASCII_M;
    len  = off + (((w * 32'd3) + 32'd3) & ~32'd3) * h;
    if (pick < 65) begin
      queue_file(w, h, off, bpp, s0, s1, 0, $urandom_range(1) ? 0 : $urandom_range(1, 3), -1);
    end else if (pick < 77) begin
      queue_file(w, h, off, bpp, s0, s1, $urandom_range(1, len), 2, -1);
    end else if (pick < 90) begin
      case ($urandom_range(5))
        0: begin
          s0 = 8'($urandom_range(255));
          if (s0 == ASCII_B) s0 = ~ASCII_B;
        end
        1: begin
          s1 = 8'($urandom_range(255));
          if (s1 == ASCII_M) s1 = ~ASCII_M;
        end
        2: begin
          bpp = 16'($urandom_range(65535));
          if (bpp == DEPTH_24) bpp = 16'd32;
        end
        3: w = $urandom_range(1) ? (32'h8000_0000 | $urandom) :
                                   32'(BMP_MAX_WIDTH + $urandom_range(1, 70000));
        4: h = $urandom_range(1) ? (32'h8000_0000 | $urandom) :
                                   32'(BMP_MAX_HEIGHT + $urandom_range(1, 70000));
        default: off = 32'($urandom_range(0, 53));
      endcase
      queue_file(w, h, off, bpp, s0, s1, 0, $urandom_range(0, 2), -1);
    end else if (pick < 95) begin
      queue_file(w, h, off, bpp, s0, s1, 0, 1, $urandom_range(0, 53));
    end else begin
      // Random noise closed by end of file
      n = $urandom_range(1, 80);
      for (i = 0; i < n; i++) push_byte(8'($urandom_range(255)), i == n - 1);
    end
  endtask

  // Hold until every queued byte is taken and every expected word has arrived
  task automatic settle();
    while (bytes_accepted != bytes_queued || words_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic run_random(input int gap, input int stall, input int goal);
    int mark;
    gap_pct   = gap;
    stall_pct = stall;
    mark      = bytes_queued + goal;
    while (bytes_queued < mark) queue_random_file();
    settle();
  endtask

  // --------------------------------------------------------------------------
  // Driver: present bytes at the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    file_byte_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || byte_taken) begin
        if (bytes_to_send.size() != 0 && $urandom_range(99) >= gap_pct) begin
          nxt = bytes_to_send.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nxt.data;
          s_tlast  <= nxt.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on accepted bytes, check accepted words
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      byte_taken <= 1'b0;
    end else begin
      byte_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        decode_byte(s_tdata, s_tlast);
        bytes_accepted++;
      end
      if (m_tvalid && m_tready) begin
        got = make_word(kind_t'(m_tuser), m_tdata[7:0], m_tdata[15:8], m_tdata[23:16],
                        m_tdata[35:24], m_tdata[47:36], m_tlast);
        if (words_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %s", $time, word_text(got));
          fail_count++;
        end else begin
          want = words_due.pop_front();
          if (got !== want) begin
            $display("%0t: word differs, expected %s, actual %s",
                     $time, word_text(want), word_text(got));
            fail_count++;
          end
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("bmp24_stream_decoder: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    clear_parser();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed files, no pacing
    queue_file(1, 1, HDR_SIZE, DEPTH_24, ASCII_B, ASCII_M, 0, 0, -1);
    queue_file(3, 2, HDR_SIZE, DEPTH_24, ASCII_B, ASCII_M, 0, 3, -1);
    queue_file(0, 0, HDR_SIZE, DEPTH_24, ASCII_B, ASCII_M, 0, 2, -1);
    queue_file(0, 0, HDR_SIZE, DEPTH_24, ASCII_B, ASCII_M, 0, 0, -1);
    queue_file(0, 3, 60, DEPTH_24, ASCII_B, ASCII_M, 0, 0, -1);
    queue_file(2, 0, 57, DEPTH_24, ASCII_B, ASCII_M, 0, 1, -1);
    // signature, depth and size errors
    queue_file(1, 1, HDR_SIZE, DEPTH_24, ~ASCII_B, ASCII_M, 0, 1, -1);
    queue_file(1, 1, HDR_SIZE, DEPTH_24, ASCII_B, ~ASCII_M, 0, 0, -1);
    queue_file(1, 1, HDR_SIZE, 16'd32, ASCII_B, ASCII_M, 0, 1, -1);
    queue_file(1, 1, HDR_SIZE, 16'h0118, ASCII_B, ASCII_M, 0, 0, -1);
    queue_file(1, 1, HDR_SIZE, 16'd8, 8'h00, ASCII_M, 0, 0, -1);
    queue_file(32'hFFFF_FFFF, 1, HDR_SIZE, DEPTH_24, ASCII_B, ASCII_M, 0, 1, -1);
    queue_file(1, 32'h8000_0000, HDR_SIZE, DEPTH_24, ASCII_B, ASCII_M, 0, 0, -1);
    queue_file(32'(BMP_MAX_WIDTH + 1), 1, HDR_SIZE, DEPTH_24, ASCII_B, ASCII_M, 0, 0, -1);
    queue_file(1, 32'(BMP_MAX_HEIGHT + 1), HDR_SIZE, DEPTH_24, ASCII_B, ASCII_M, 0, 0, -1);
    queue_file(1, 1, 53, DEPTH_24, ASCII_B, ASCII_M, 0, 1, -1);
    // short header and short files
    queue_file(2, 2, HDR_SIZE, DEPTH_24, ASCII_B, ASCII_M, 20, 0, -1);
    queue_file(2, 2, HDR_SIZE, DEPTH_24, ASCII_B, ASCII_M, 1, 0, -1);
    queue_file(2, 2, HDR_SIZE, DEPTH_24, ASCII_B, ASCII_M, 54, 0, -1);
    queue_file(2, 2, 60, DEPTH_24, ASCII_B, ASCII_M, 54, 0, -1);
    queue_file(2, 2, 60, DEPTH_24, ASCII_B, ASCII_M, 57, 0, -1);
    queue_file(4, 2, HDR_SIZE, DEPTH_24, ASCII_B, ASCII_M, 58, 0, -1);
    queue_file(4, 2, HDR_SIZE, DEPTH_24, ASCII_B, ASCII_M, 60, 0, -1);
    queue_file(1, 2, HDR_SIZE, DEPTH_24, ASCII_B, ASCII_M, 58, 0, -1);
    // largest width and height, cut short after a few pixels
    queue_file(32'(BMP_MAX_WIDTH), 1, HDR_SIZE, DEPTH_24, ASCII_B, ASCII_M, 66, 0, -1);
    queue_file(1, 32'(BMP_MAX_HEIGHT), HDR_SIZE, DEPTH_24, ASCII_B, ASCII_M, 66, 0, -1);
    settle();

    // Random files under each pacing
    run_random(87, 0, 60);
    run_random(0, 87, 60);
    run_random(18, 18, 60);

    if (fail_count == 0) begin
      $display("bmp24_stream_decoder: match");
    end else begin
      $display("bmp24_stream_decoder: mismatch");
    end
    $finish;
  end

endmodule
